// ===== hdl/ecpd_pkg.sv =====
// ecpd_pkg: shared types and constants for the event channel pending dispatcher
// request codes, controller states, command/status structs and the result beat
// no dependencies
package ecpd_pkg;

    localparam int PORT_W    = 10;
    localparam int REQ_W     = 2;
    localparam int SEL_WORDS = 32;
    localparam int SEL_IDX_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_RAISE   = 2'd0,
        REQ_MASK    = 2'd1,
        REQ_UNMASK  = 2'd2,
        REQ_SERVICE = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_APPLY,
        S_SNAP,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic split;
        logic apply;
        logic snap;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic snap_zero;
        logic hit;
    } t_dp_stat;

    typedef struct packed {
        logic              dispatched;
        logic [PORT_W-1:0] out_port;
        logic              upcall_irq;
        logic              bad_port;
    } t_rsp;

endpackage

// ===== hdl/ecpd_req_if.sv =====
// ecpd_req_if: request channel, valid/ready with request type and port
// depends on ecpd_pkg
interface ecpd_req_if;
    logic                          valid;
    logic                          ready;
    logic [ecpd_pkg::REQ_W-1:0]    req_type;
    logic [ecpd_pkg::PORT_W-1:0]   port;

    modport source (output valid, output req_type, output port, input ready);
    modport sink   (input valid, input req_type, input port, output ready);
endinterface

// ===== hdl/ecpd_rsp_if.sv =====
// ecpd_rsp_if: result channel, valid/ready with dispatch result fields
// depends on ecpd_pkg
interface ecpd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          dispatched;
    logic [ecpd_pkg::PORT_W-1:0]   out_port;
    logic                          upcall_irq;
    logic                          bad_port;

    modport source (output valid, output dispatched, output out_port,
                    output upcall_irq, output bad_port, input ready);
    modport sink   (input valid, input dispatched, input out_port,
                    input upcall_irq, input bad_port, output ready);
endinterface

// ===== hdl/ecpd_ctrl.sv =====
// ecpd_ctrl: sequencing state machine and result valid register
// depends on ecpd_pkg
module ecpd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_service,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output ecpd_pkg::t_dp_cmd  o_cmd,
    input  ecpd_pkg::t_dp_stat i_stat
);

    ecpd_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ecpd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_service ? ecpd_pkg::S_SNAP : ecpd_pkg::S_SPLIT;
                end
            end
            ecpd_pkg::S_SPLIT:  n_state = ecpd_pkg::S_APPLY;
            ecpd_pkg::S_APPLY:  n_state = ecpd_pkg::S_FINISH;
            ecpd_pkg::S_SNAP:   n_state = ecpd_pkg::S_SCAN;
            ecpd_pkg::S_SCAN: begin
                if (i_stat.snap_zero || i_stat.hit) begin
                    n_state = ecpd_pkg::S_FINISH;
                end
            end
            ecpd_pkg::S_FINISH: begin
                if (slot_free) begin
                    n_state = ecpd_pkg::S_IDLE;
                end
            end
            default: n_state = ecpd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ecpd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ecpd_pkg::S_SPLIT:  o_cmd.split  = 1'b1;
            ecpd_pkg::S_APPLY:  o_cmd.apply  = 1'b1;
            ecpd_pkg::S_SNAP:   o_cmd.snap   = 1'b1;
            ecpd_pkg::S_SCAN:   o_cmd.scan   = !i_stat.snap_zero;
            ecpd_pkg::S_FINISH: o_cmd.finish = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecpd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/ecpd_dp.sv =====
// ecpd_dp: pending/mask words, selector, snapshot, port decode and result register
// depends on ecpd_pkg
module ecpd_dp #(
    parameter int NUM_PORTS = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ecpd_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ecpd_pkg::PORT_W-1:0]  i_port,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_wdata,
    input  ecpd_pkg::t_dp_cmd            i_cmd,
    output ecpd_pkg::t_dp_stat           o_stat,
    output ecpd_pkg::t_rsp               o_rsp
);

    localparam int PW       = ecpd_pkg::PORT_W;
    localparam int SW       = ecpd_pkg::SEL_WORDS;
    localparam int SIW      = ecpd_pkg::SEL_IDX_W;
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int RECIP_SH = 16;
    localparam int RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W   = PW + RECIP_SH + 1;
    localparam int AW       = 16;

    logic [WORD_BITS-1:0] r_pend [SW];
    logic [WORD_BITS-1:0] r_mask [SW];
    logic [SW-1:0]        r_sel;
    logic [SW-1:0]        r_snap;
    logic                 r_upc;
    logic                 r_upmask;

    ecpd_pkg::t_req       r_req;
    logic [PW-1:0]        r_port;
    logic [PW-1:0]        r_quot;
    logic [SIW-1:0]       r_word;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_bad;
    logic                 r_disp;
    ecpd_pkg::t_rsp       r_rsp;

    // quotient by reciprocal multiply, exact for 10-bit ports and divisors up to 32
    logic [PROD_W-1:0]    prod;
    assign prod = PROD_W'(i_port) * PROD_W'(RECIP);

    // remainder with a one-step correction
    logic [AW-1:0]        rem0;
    logic [AW-1:0]        rem1;
    logic [PW-1:0]        quot1;
    logic                 bad_n;
    always_comb begin
        rem0  = AW'(r_port) - AW'(r_quot) * AW'(WORD_BITS);
        rem1  = rem0;
        quot1 = r_quot;
        if (rem0 >= AW'(WORD_BITS)) begin
            rem1  = rem0 - AW'(WORD_BITS);
            quot1 = r_quot + PW'(1);
        end
        bad_n = ({1'b0, r_port} >= (PW+1)'(NUM_PORTS)) || (quot1 >= PW'(SW));
    end

    // lowest selector word still in the snapshot
    logic [SIW-1:0] scan_word;
    always_comb begin
        scan_word = SIW'(SW - 1);
        for (int i = SW - 1; i >= 0; i--) begin
            if (r_snap[i]) begin
                scan_word = SIW'(i);
            end
        end
    end

    // one shared read port on the pending and mask words
    logic [SIW-1:0]       rd_addr;
    logic [WORD_BITS-1:0] rd_pend;
    logic [WORD_BITS-1:0] rd_mask;
    logic [WORD_BITS-1:0] act;
    logic [BIT_W-1:0]     act_bit;
    logic [WORD_BITS-1:0] bit_oh;

    assign rd_addr = i_cmd.scan ? scan_word : r_word;
    assign rd_pend = r_pend[rd_addr];
    assign rd_mask = r_mask[rd_addr];
    assign act     = rd_pend & ~rd_mask;
    assign bit_oh  = WORD_BITS'(1) << r_bit;

    always_comb begin
        act_bit = BIT_W'(WORD_BITS - 1);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (act[i]) begin
                act_bit = BIT_W'(i);
            end
        end
    end

    assign o_stat.snap_zero = (r_snap == '0);
    assign o_stat.hit       = (act != '0);

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SW; i++) begin
                r_pend[i] <= '0;
                r_mask[i] <= '1;
            end
            r_sel    <= '0;
            r_snap   <= '0;
            r_upc    <= 1'b0;
            r_upmask <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_upmask <= i_cfg_wdata;
            end
            if (i_cmd.apply && !r_bad) begin
                unique case (r_req)
                    ecpd_pkg::REQ_RAISE: begin
                        if ((rd_pend & bit_oh) == '0) begin
                            r_pend[r_word] <= rd_pend | bit_oh;
                            if ((rd_mask & bit_oh) == '0 && !r_sel[r_word]) begin
                                r_sel[r_word] <= 1'b1;
                                r_upc         <= 1'b1;
                            end
                        end
                    end
                    ecpd_pkg::REQ_MASK: begin
                        r_mask[r_word] <= rd_mask | bit_oh;
                    end
                    ecpd_pkg::REQ_UNMASK: begin
                        r_mask[r_word] <= rd_mask & ~bit_oh;
                        if ((rd_pend & bit_oh) != '0 && !r_sel[r_word]) begin
                            r_sel[r_word] <= 1'b1;
                            r_upc         <= 1'b1;
                        end
                    end
                    ecpd_pkg::REQ_SERVICE: ;
                    default: ;
                endcase
            end
            if (i_cmd.snap && r_snap == '0) begin
                r_snap <= r_sel;
                r_sel  <= '0;
                r_upc  <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (act == '0) begin
                    r_snap[scan_word] <= 1'b0;
                end else begin
                    r_pend[scan_word] <= rd_pend & ~(WORD_BITS'(1) << act_bit);
                end
            end
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= ecpd_pkg::t_req'(i_req_type);
            r_port <= i_port;
            r_quot <= prod[RECIP_SH+PW-1:RECIP_SH];
            r_bad  <= 1'b0;
            r_disp <= 1'b0;
        end
        if (i_cmd.split) begin
            r_word <= quot1[SIW-1:0];
            r_bit  <= rem1[BIT_W-1:0];
            r_bad  <= bad_n;
        end
        if (i_cmd.scan && act != '0) begin
            r_word <= scan_word;
            r_bit  <= act_bit;
            r_disp <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_rsp.dispatched <= r_disp;
            r_rsp.out_port   <= r_disp
                ? PW'(AW'(r_word) * AW'(WORD_BITS) + AW'(r_bit)) : '0;
            r_rsp.upcall_irq <= r_upc & ~r_upmask;
            r_rsp.bad_port   <= r_bad;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== hdl/event_channel_pending_dispatcher.sv =====
// event_channel_pending_dispatcher: top level of the event channel pending dispatcher
// instantiates ecpd_ctrl and ecpd_dp; channels use ecpd_req_if and ecpd_rsp_if
//
//   channel   direction  beat contents                                   handshake
//   i_req     in         req_type, port                                  valid/ready
//   o_rsp     out        dispatched, out_port, upcall_irq, bad_port      valid/ready
//   i_cfg     in         upcall_mask in i_cfg_wdata                      i_cfg_we
//
// raise, mask and unmask step through accept, port split, word update and result
// service steps through accept, snapshot, scan and result; the scan examines one selector
// word a cycle through the single read port until a hit or until the snapshot runs out
// reset is synchronous and puts every word at its reset value at once, no clearing pass
// the result waits in an output register; the next beat is accepted while it waits,
// and a later result holds in the finish state until the output register frees up
module event_channel_pending_dispatcher #(
    parameter int NUM_PORTS = 1024,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecpd_req_if.sink          i_req,
    ecpd_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    ecpd_pkg::t_dp_cmd  cmd;
    ecpd_pkg::t_dp_stat stat;
    ecpd_pkg::t_rsp     rsp;
    logic               in_service;

    // service beats skip the port split and go straight to the snapshot step
    assign in_service = (i_req.req_type == ecpd_pkg::REQ_SERVICE);

    // sequencer: owns the handshakes and steps the datapath
    ecpd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_in_service (in_service),
        .o_in_ready   (i_req.ready),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    // datapath: pending and mask words, selector, snapshot, result payload
    ecpd_dp #(
        .NUM_PORTS (NUM_PORTS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req.req_type),
        .i_port      (i_req.port),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp       (rsp)
    );

    // result payload straight from the output register
    assign o_rsp.dispatched = rsp.dispatched;
    assign o_rsp.out_port   = rsp.out_port;
    assign o_rsp.upcall_irq = rsp.upcall_irq;
    assign o_rsp.bad_port   = rsp.bad_port;

endmodule

// ===== sim/event_channel_pending_dispatcher_tb.sv =====
// event_channel_pending_dispatcher_tb: self-checking bench for the event channel dispatcher
// drives raise, mask, unmask and service beats, predicts every result beat and checks it
// depends on ecpd_pkg, ecpd_req_if, ecpd_rsp_if and event_channel_pending_dispatcher
module event_channel_pending_dispatcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecpd_pkg::*;

    localparam int NUM_PORTS   = 1024;
    localparam int WORD_BITS   = 32;
    localparam int CYCLE_LIMIT = 400000;

    // tracks port state and holds the result beats still owed by the block
    class event_state_tracker;
        bit [WORD_BITS-1:0] pend_word [SEL_WORDS];
        bit [WORD_BITS-1:0] mask_word [SEL_WORDS];
        bit [SEL_WORDS-1:0] sel_word;
        bit [SEL_WORDS-1:0] scan_left;
        bit                 upcall_flag;
        bit                 upcall_off;
        t_rsp               rsp_due [$];
        int                 errors;

        function new();
            foreach (pend_word[i]) begin
                pend_word[i] = '0;
                mask_word[i] = '1;
            end
            sel_word    = '0;
            scan_left   = '0;
            upcall_flag = 1'b0;
            upcall_off  = 1'b0;
            errors      = 0;
        endfunction

        function int unsigned lowest_one(bit [31:0] v);
            for (int i = 0; i < 32; i++)
                if (v[i])
                    return i;
            return 31;
        endfunction

        // applies one accepted request to the tracked state and queues its result
        function void note_request(t_req kind, logic [PORT_W-1:0] port);
            t_rsp               res;
            int unsigned        w;
            int unsigned        b;
            bit [WORD_BITS-1:0] act;
            bit                 hit;
            res = '0;
            if (kind != REQ_SERVICE) begin
                w = port / WORD_BITS;
                b = port % WORD_BITS;
                if (port >= NUM_PORTS || w >= SEL_WORDS) begin
                    res.bad_port = 1'b1;
                end else begin
                    case (kind)
                        REQ_RAISE: begin
                            if (!pend_word[w][b]) begin
                                pend_word[w][b] = 1'b1;
                                if (!mask_word[w][b] && !sel_word[w]) begin
                                    sel_word[w] = 1'b1;
                                    upcall_flag = 1'b1;
                                end
                            end
                        end
                        REQ_MASK: begin
                            mask_word[w][b] = 1'b1;
                        end
                        default: begin
                            mask_word[w][b] = 1'b0;
                            if (pend_word[w][b] && !sel_word[w]) begin
                                sel_word[w] = 1'b1;
                                upcall_flag = 1'b1;
                            end
                        end
                    endcase
                end
            end else begin
                if (scan_left == '0) begin
                    upcall_flag = 1'b0;
                    scan_left   = sel_word;
                    sel_word    = '0;
                end
                hit = 1'b0;
                while (scan_left != '0 && !hit) begin
                    w   = lowest_one(scan_left);
                    act = pend_word[w] & ~mask_word[w];
                    if (act == '0) begin
                        scan_left[w] = 1'b0;
                    end else begin
                        b               = lowest_one(act);
                        pend_word[w][b] = 1'b0;
                        res.dispatched  = 1'b1;
                        res.out_port    = PORT_W'(w * WORD_BITS + b);
                        hit             = 1'b1;
                    end
                end
            end
            res.upcall_irq = upcall_flag & ~upcall_off;
            rsp_due.push_back(res);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (rsp_due.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
                return;
            end
            want = rsp_due.pop_front();
            if (got.dispatched !== want.dispatched) begin
                $error("dispatched: expected %0d, got %0d", want.dispatched, got.dispatched);
                errors++;
            end
            if (got.out_port !== want.out_port) begin
                $error("out_port: expected %0d, got %0d", want.out_port, got.out_port);
                errors++;
            end
            if (got.upcall_irq !== want.upcall_irq) begin
                $error("upcall_irq: expected %0d, got %0d", want.upcall_irq, got.upcall_irq);
                errors++;
            end
            if (got.bad_port !== want.bad_port) begin
                $error("bad_port: expected %0d, got %0d", want.bad_port, got.bad_port);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    ecpd_req_if req_ch ();
    ecpd_rsp_if rsp_ch ();

    event_state_tracker tracker = new();

    // percent of cycles the sender holds off and the receiver stalls
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles = 0;

    event_channel_pending_dispatcher #(
        .NUM_PORTS (NUM_PORTS),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // every input known from time zero
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_RAISE;
        req_ch.port     = '0;
        rsp_ch.ready    = 1'b0;
    end

    // receiver side: random stall on the result channel
    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // every accepted result beat goes against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result('{dispatched: rsp_ch.dispatched, out_port: rsp_ch.out_port,
                                   upcall_irq: rsp_ch.upcall_irq, bad_port: rsp_ch.bad_port});
        end
    end

    // watchdog on a hung handshake
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("event_channel_pending_dispatcher_tb failed");
            $finish;
        end
    end

    // one request beat: optional hold-off, then valid stays up until accepted
    task automatic send_request(t_req kind, logic [PORT_W-1:0] port);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.port     <= port;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        tracker.note_request(kind, port);
    endtask

    // wait for every owed result, then let the block settle
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.rsp_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic write_upcall_mask(bit value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.upcall_off = value;
        i_cfg_we <= 1'b0;
    endtask

    // mostly ports in a few busy words so scans hit, the rest anywhere
    function automatic logic [PORT_W-1:0] pick_port();
        int unsigned w;
        if ($urandom_range(0, 99) < 25)
            return PORT_W'($urandom_range(0, NUM_PORTS - 1));
        case ($urandom_range(0, 3))
            0:       w = 0;
            1:       w = 1;
            2:       w = SEL_WORDS - 1;
            default: w = $urandom_range(0, SEL_WORDS - 1);
        endcase
        return PORT_W'(w * WORD_BITS + $urandom_range(0, WORD_BITS - 1));
    endfunction

    task automatic random_requests(int unsigned count);
        int unsigned roll;
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
                send_request(REQ_RAISE, pick_port());
            else if (roll < 50)
                send_request(REQ_MASK, pick_port());
            else if (roll < 72)
                send_request(REQ_UNMASK, pick_port());
            else
                send_request(REQ_SERVICE, PORT_W'($urandom_range(0, NUM_PORTS - 1)));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_upcall_mask(1'b0);

        // directed: empty service, masked raise, repeat raise, posting by unmask
        send_request(REQ_SERVICE, '1);
        send_request(REQ_RAISE, 10'd0);
        send_request(REQ_RAISE, 10'd0);
        send_request(REQ_UNMASK, 10'd0);
        send_request(REQ_UNMASK, 10'd1023);
        send_request(REQ_RAISE, 10'd1023);
        send_request(REQ_RAISE, 10'd5);
        send_request(REQ_UNMASK, 10'd5);
        send_request(REQ_RAISE, 10'd31);
        send_request(REQ_UNMASK, 10'd31);
        // scan starts; a raise mid-scan waits for a later snapshot
        send_request(REQ_SERVICE, 10'd0);
        send_request(REQ_RAISE, 10'd992);
        send_request(REQ_UNMASK, 10'd992);
        send_request(REQ_SERVICE, 10'd682);
        // masking the last active port of a word makes the scan drop it
        send_request(REQ_MASK, 10'd31);
        send_request(REQ_SERVICE, 10'd341);
        send_request(REQ_SERVICE, 10'd0);
        send_request(REQ_SERVICE, 10'd0);
        send_request(REQ_SERVICE, 10'd0);
        send_request(REQ_SERVICE, 10'd0);
        send_request(REQ_MASK, 10'd1023);
        send_request(REQ_RAISE, 10'd1023);
        send_request(REQ_UNMASK, 10'd1023);
        send_request(REQ_SERVICE, 10'd1023);
        send_request(REQ_SERVICE, 10'd0);

        write_upcall_mask(1'b1);
        send_idle_pct  = 18;
        recv_stall_pct = 58;
        random_requests(500);

        write_upcall_mask(1'b0);
        send_idle_pct  = 58;
        recv_stall_pct = 18;
        random_requests(500);

        write_upcall_mask(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_requests(250);

        write_upcall_mask(1'b0);
        random_requests(250);

        drain();
        if (tracker.errors == 0 && tracker.rsp_due.size() == 0) begin
            $display("event_channel_pending_dispatcher_tb passed");
        end else begin
            $display("event_channel_pending_dispatcher_tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ecpd_pkg.sv
hdl/ecpd_req_if.sv
hdl/ecpd_rsp_if.sv
hdl/ecpd_ctrl.sv
hdl/ecpd_dp.sv
hdl/event_channel_pending_dispatcher.sv
sim/event_channel_pending_dispatcher_tb.sv
